// File: hdl/bfpm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfpm_pkg
// Shared codes, payload types and controller/datapath command types for the
// buffer frame pin manager.
// ---------------------------------------------------------------------------
package bfpm_pkg;

	// operation codes on the request channel
	localparam logic [2:0] OP_PIN     = 3'd0;
	localparam logic [2:0] OP_UNPIN   = 3'd1;
	localparam logic [2:0] OP_ALLOC   = 3'd2;
	localparam logic [2:0] OP_DISPOSE = 3'd3;
	localparam logic [2:0] OP_FLUSH   = 3'd4;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_FILE,
		ST_ALL_PINNED,
		ST_NOT_FOUND,
		ST_NOT_PINNED,
		ST_PINNED,
		ST_DUPLICATE
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_FOUND,
		S_MISS,
		S_VICTIM,
		S_SET,
		S_FLUSH,
		S_FL_PIN,
		S_FL_END
	} state_t;

	// frame index source for a result
	typedef enum logic [1:0] {
		FS_NONE,
		FS_X,
		FS_V,
		FS_SC
	} fsel_t;

	// result source: freshly built or the held flush write-back
	typedef enum logic {
		SRC_NEW,
		SRC_PEND
	} src_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  file_id;
		logic [23:0] page_no;
		logic        mark_dirty;
		logic        keep_recent;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  frame;
		logic        hit;
		logic        fetch;
		logic        wb_valid;
		logic [7:0]  wb_file;
		logic [23:0] wb_page;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic    load_in;
		logic    sc_clr;
		logic    sc_inc;
		logic    x_load;
		logic    take_vic;
		logic    set_v;
		logic    hit_upd;
		logic    unpin_upd;
		logic    ins_rear_v;
		logic    clr_x;
		logic    clr_sc;
		logic    pend_load;
		logic    pend_clr;
		logic    emit;
		src_t    src;
		status_t st;
		fsel_t   fsel;
		logic    hit;
		logic    fetch;
		logic    wb;
		logic    last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       file_zero;
		logic       match;
		logic       sc_last;
		logic       rear_empty;
		logic       x_pin_zero;
		logic       sc_fm;
		logic       sc_pinned;
		logic       sc_dirty;
		logic       pend_valid;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: hdl/bfpm_req_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfpm_req_if
// Request channel: valid/ready handshake with one operation per transfer.
// ---------------------------------------------------------------------------
interface bfpm_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [7:0]  file_id;
	logic [23:0] page_no;
	logic        mark_dirty;
	logic        keep_recent;

	modport source(output valid, op, file_id, page_no, mark_dirty, keep_recent,
		input ready);
	modport sink(input valid, op, file_id, page_no, mark_dirty, keep_recent,
		output ready);
endinterface
`default_nettype wire

// File: hdl/bfpm_rsp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfpm_rsp_if
// Result channel: valid/ready handshake with one result per transfer.
// ---------------------------------------------------------------------------
interface bfpm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  frame;
	logic        hit;
	logic        fetch;
	logic        wb_valid;
	logic [7:0]  wb_file;
	logic [23:0] wb_page;
	logic        last;

	modport source(output valid, status, frame, hit, fetch, wb_valid, wb_file,
		wb_page, last, input ready);
	modport sink(input valid, status, frame, hit, fetch, wb_valid, wb_file,
		wb_page, last, output ready);
endinterface
`default_nettype wire

// File: hdl/bfpm_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfpm_dpath
// Frame tables, unpinned list links, scan counter and the result register.
// ---------------------------------------------------------------------------
module bfpm_dpath #(
	parameter int NUM_FRAMES = 16,
	parameter int PIN_BITS   = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  bfpm_pkg::in_item_t  in_item,
	input  bfpm_pkg::cmd_t      cmd,
	output bfpm_pkg::stat_t     stat,
	output bfpm_pkg::out_item_t out_item,
	output logic                out_valid,
	input  wire                 out_ready
);
	localparam int IW = $clog2(NUM_FRAMES);
	localparam int LW = $clog2(NUM_FRAMES + 1);
	localparam logic [LW-1:0] SENT = LW'(NUM_FRAMES);
	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

	// latched request
	bfpm_pkg::in_item_t req_q;

	// frame tables
	logic [7:0]          tag_file_q  [NUM_FRAMES];
	logic [23:0]         tag_page_q  [NUM_FRAMES];
	logic [PIN_BITS-1:0] pin_q       [NUM_FRAMES];
	logic                dirty_q     [NUM_FRAMES];
	logic                valid_q     [NUM_FRAMES];
	logic [LW-1:0]       next_q      [NUM_FRAMES+1];
	logic [LW-1:0]       prior_q     [NUM_FRAMES+1];
	logic [LW-1:0]       rear_q;

	logic [IW-1:0] sc_q, x_q, v_q;
	logic          wbv_q;
	logic [7:0]    wbf_q;
	logic [23:0]   wbp_q;
	logic          pend_valid_q;
	logic [IW-1:0] pend_fr_q;
	logic [7:0]    pend_file_q;
	logic [23:0]   pend_page_q;

	logic                out_valid_q;
	bfpm_pkg::out_item_t out_q;

	logic [IW-1:0] rear_fr;
	logic          out_free;
	assign rear_fr  = rear_q[IW-1:0];
	assign out_free = !out_valid_q || out_ready;

	// status toward the controller
	always_comb begin
		stat.op         = req_q.op;
		stat.file_zero  = (req_q.file_id == 8'd0);
		stat.match      = valid_q[sc_q] && tag_file_q[sc_q] == req_q.file_id &&
			tag_page_q[sc_q] == req_q.page_no;
		stat.sc_last    = (sc_q == IW'(NUM_FRAMES - 1));
		stat.rear_empty = (rear_q == SENT);
		stat.x_pin_zero = (pin_q[x_q] == '0);
		stat.sc_fm      = valid_q[sc_q] && tag_file_q[sc_q] == req_q.file_id;
		stat.sc_pinned  = (pin_q[sc_q] != '0);
		stat.sc_dirty   = dirty_q[sc_q];
		stat.pend_valid = pend_valid_q;
		stat.out_free   = out_free;
	end

	// pick the one list edit of this cycle
	logic          lk_unlink, lk_front, lk_rear;
	logic [LW-1:0] lk_f, u_nx, u_pv, fr_pv, r_pv;
	always_comb begin
		lk_unlink = 1'b0;
		lk_front  = 1'b0;
		lk_rear   = 1'b0;
		lk_f      = SENT;
		if (cmd.take_vic) begin
			lk_unlink = 1'b1;
			lk_f      = rear_q;
		end else if (cmd.hit_upd && pin_q[x_q] == '0) begin
			lk_unlink = 1'b1;
			lk_f      = LW'(x_q);
		end else if (cmd.unpin_upd && pin_q[x_q] == PIN_BITS'(1)) begin
			lk_front  = req_q.keep_recent;
			lk_rear   = !req_q.keep_recent;
			lk_f      = LW'(x_q);
		end else if (cmd.ins_rear_v) begin
			lk_rear   = 1'b1;
			lk_f      = LW'(v_q);
		end
		u_nx  = next_q[lk_f];
		u_pv  = prior_q[lk_f];
		fr_pv = prior_q[SENT];
		r_pv  = prior_q[rear_q];
	end

	// apply list edits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FRAMES; i++) begin
				next_q[i]  <= LW'(i + 1);
				prior_q[i] <= (i == 0) ? SENT : LW'(i - 1);
			end
			next_q[NUM_FRAMES]  <= '0;
			prior_q[NUM_FRAMES] <= LW'(NUM_FRAMES - 1);
			rear_q              <= '0;
		end else if (lk_unlink) begin
			if (rear_q == lk_f) begin
				rear_q <= u_nx;
			end
			next_q[u_pv]  <= u_nx;
			prior_q[u_nx] <= u_pv;
		end else if (lk_front) begin
			next_q[lk_f]   <= SENT;
			prior_q[lk_f]  <= fr_pv;
			next_q[fr_pv]  <= lk_f;
			prior_q[SENT]  <= lk_f;
			if (rear_q == SENT) begin
				rear_q <= lk_f;
			end
		end else if (lk_rear) begin
			next_q[lk_f]    <= rear_q;
			prior_q[lk_f]   <= r_pv;
			next_q[r_pv]    <= lk_f;
			prior_q[rear_q] <= lk_f;
			rear_q          <= lk_f;
		end
	end

	// valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FRAMES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.take_vic) begin
				valid_q[rear_fr] <= 1'b0;
			end
			if (cmd.set_v) begin
				valid_q[v_q] <= 1'b1;
			end
			if (cmd.clr_x) begin
				valid_q[x_q] <= 1'b0;
			end
			if (cmd.clr_sc) begin
				valid_q[sc_q] <= 1'b0;
			end
		end
	end

	// tags, pin counts, dirty marks
	always_ff @(posedge clk) begin
		if (cmd.set_v) begin
			tag_file_q[v_q] <= req_q.file_id;
			tag_page_q[v_q] <= req_q.page_no;
			pin_q[v_q]      <= PIN_BITS'(1);
			dirty_q[v_q]    <= 1'b0;
		end
		if (cmd.hit_upd && pin_q[x_q] != PIN_MAX) begin
			pin_q[x_q] <= pin_q[x_q] + PIN_BITS'(1);
		end
		if (cmd.unpin_upd) begin
			pin_q[x_q] <= pin_q[x_q] - PIN_BITS'(1);
			if (req_q.mark_dirty) begin
				dirty_q[x_q] <= 1'b1;
			end
		end
	end

	// request latch, scan counter, victim and write-back capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q <= in_item;
		end
		if (cmd.sc_clr) begin
			sc_q <= '0;
		end else if (cmd.sc_inc) begin
			sc_q <= sc_q + IW'(1);
		end
		if (cmd.x_load) begin
			x_q <= sc_q;
		end
		if (cmd.take_vic) begin
			v_q   <= rear_fr;
			wbv_q <= valid_q[rear_fr] && dirty_q[rear_fr];
			wbf_q <= (valid_q[rear_fr] && dirty_q[rear_fr]) ? tag_file_q[rear_fr] : 8'd0;
			wbp_q <= (valid_q[rear_fr] && dirty_q[rear_fr]) ? tag_page_q[rear_fr] : 24'd0;
		end
		if (cmd.pend_load) begin
			pend_fr_q   <= sc_q;
			pend_file_q <= tag_file_q[sc_q];
			pend_page_q <= tag_page_q[sc_q];
		end
	end

	// held flush write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.pend_load) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.pend_clr) begin
			pend_valid_q <= 1'b0;
		end
	end

	// assemble the result
	logic [IW-1:0]       fr_idx;
	logic [IW+3:0]       fr_ext;
	bfpm_pkg::out_item_t res;
	always_comb begin
		unique case (cmd.fsel)
			bfpm_pkg::FS_X:  fr_idx = x_q;
			bfpm_pkg::FS_V:  fr_idx = v_q;
			bfpm_pkg::FS_SC: fr_idx = sc_q;
			default:         fr_idx = '0;
		endcase
		if (cmd.src == bfpm_pkg::SRC_PEND) begin
			fr_ext       = {4'b0, pend_fr_q};
			res.status   = bfpm_pkg::ST_OK;
			res.hit      = 1'b0;
			res.fetch    = 1'b0;
			res.wb_valid = 1'b1;
			res.wb_file  = pend_file_q;
			res.wb_page  = pend_page_q;
		end else begin
			fr_ext       = {4'b0, fr_idx};
			res.status   = cmd.st;
			res.hit      = cmd.hit;
			res.fetch    = cmd.fetch;
			res.wb_valid = cmd.wb && wbv_q;
			res.wb_file  = cmd.wb ? wbf_q : 8'd0;
			res.wb_page  = cmd.wb ? wbp_q : 24'd0;
		end
		res.frame = fr_ext[3:0];
		res.last  = cmd.last;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule
`default_nettype wire

// File: hdl/bfpm_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfpm_ctrl
// Operation sequencer: decodes one request, steers the scan, victim take,
// list edits and result transfers of the datapath.
// ---------------------------------------------------------------------------
module bfpm_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  bfpm_pkg::stat_t  stat,
	output bfpm_pkg::cmd_t   cmd
);
	bfpm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfpm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfpm_pkg::S_IDLE: begin
				if (req_valid) state_d = bfpm_pkg::S_DECODE;
			end
			bfpm_pkg::S_DECODE: begin
				if (stat.op > bfpm_pkg::OP_FLUSH || stat.file_zero) begin
					if (stat.out_free) state_d = bfpm_pkg::S_IDLE;
				end else if (stat.op == bfpm_pkg::OP_ALLOC) begin
					state_d = bfpm_pkg::S_VICTIM;
				end else if (stat.op == bfpm_pkg::OP_FLUSH) begin
					state_d = bfpm_pkg::S_FLUSH;
				end else begin
					state_d = bfpm_pkg::S_SCAN;
				end
			end
			bfpm_pkg::S_SCAN: begin
				if (stat.match) state_d = bfpm_pkg::S_FOUND;
				else if (stat.sc_last) state_d = bfpm_pkg::S_MISS;
			end
			bfpm_pkg::S_FOUND, bfpm_pkg::S_SET: begin
				if (stat.out_free) state_d = bfpm_pkg::S_IDLE;
			end
			bfpm_pkg::S_MISS: begin
				if (stat.op == bfpm_pkg::OP_PIN) state_d = bfpm_pkg::S_VICTIM;
				else if (stat.out_free) state_d = bfpm_pkg::S_IDLE;
			end
			bfpm_pkg::S_VICTIM: begin
				if (stat.rear_empty) begin
					if (stat.out_free) state_d = bfpm_pkg::S_IDLE;
				end else if (stat.op == bfpm_pkg::OP_PIN) begin
					state_d = bfpm_pkg::S_SET;
				end else begin
					state_d = bfpm_pkg::S_SCAN;
				end
			end
			bfpm_pkg::S_FLUSH: begin
				if (stat.sc_fm && stat.sc_pinned) begin
					state_d = bfpm_pkg::S_FL_PIN;
				end else if (stat.sc_fm && stat.sc_dirty && stat.pend_valid &&
					!stat.out_free) begin
					state_d = bfpm_pkg::S_FLUSH;
				end else if (stat.sc_last) begin
					state_d = bfpm_pkg::S_FL_END;
				end
			end
			bfpm_pkg::S_FL_PIN: begin
				if (stat.out_free && !stat.pend_valid) state_d = bfpm_pkg::S_IDLE;
			end
			bfpm_pkg::S_FL_END: begin
				// the final transfer is either the held write-back or the status
				if (stat.out_free) state_d = bfpm_pkg::S_IDLE;
			end
			default: state_d = bfpm_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			bfpm_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				cmd.load_in = req_valid;
			end
			bfpm_pkg::S_DECODE: begin
				cmd.sc_clr = 1'b1;
				cmd.last   = 1'b1;
				if (stat.op > bfpm_pkg::OP_FLUSH) begin
					cmd.emit = stat.out_free;
					cmd.st   = bfpm_pkg::ST_OK;
				end else if (stat.file_zero) begin
					cmd.emit = stat.out_free;
					cmd.st   = bfpm_pkg::ST_BAD_FILE;
				end
			end
			bfpm_pkg::S_SCAN: begin
				cmd.x_load = stat.match;
				cmd.sc_inc = !stat.match && !stat.sc_last;
			end
			bfpm_pkg::S_FOUND: begin
				cmd.fsel = bfpm_pkg::FS_X;
				cmd.last = 1'b1;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					unique case (stat.op)
						bfpm_pkg::OP_PIN: begin
							cmd.hit_upd = 1'b1;
							cmd.hit     = 1'b1;
							cmd.st      = bfpm_pkg::ST_OK;
						end
						bfpm_pkg::OP_UNPIN: begin
							cmd.unpin_upd = !stat.x_pin_zero;
							cmd.st = stat.x_pin_zero ? bfpm_pkg::ST_NOT_PINNED
								: bfpm_pkg::ST_OK;
						end
						bfpm_pkg::OP_DISPOSE: begin
							cmd.clr_x = stat.x_pin_zero;
							cmd.st = stat.x_pin_zero ? bfpm_pkg::ST_OK
								: bfpm_pkg::ST_PINNED;
						end
						default: begin
							cmd.ins_rear_v = 1'b1;
							cmd.wb         = 1'b1;
							cmd.st         = bfpm_pkg::ST_DUPLICATE;
						end
					endcase
				end
			end
			bfpm_pkg::S_MISS: begin
				cmd.last = 1'b1;
				if (stat.op == bfpm_pkg::OP_ALLOC) begin
					cmd.emit  = stat.out_free;
					cmd.set_v = stat.out_free;
					cmd.fsel  = bfpm_pkg::FS_V;
					cmd.wb    = 1'b1;
					cmd.st    = bfpm_pkg::ST_OK;
				end else if (stat.op != bfpm_pkg::OP_PIN) begin
					cmd.emit = stat.out_free;
					cmd.st   = bfpm_pkg::ST_NOT_FOUND;
				end
			end
			bfpm_pkg::S_VICTIM: begin
				cmd.last = 1'b1;
				if (stat.rear_empty) begin
					cmd.emit = stat.out_free;
					cmd.st   = bfpm_pkg::ST_ALL_PINNED;
				end else begin
					cmd.take_vic = 1'b1;
					cmd.sc_clr   = 1'b1;
				end
			end
			bfpm_pkg::S_SET: begin
				cmd.emit  = stat.out_free;
				cmd.set_v = stat.out_free;
				cmd.fsel  = bfpm_pkg::FS_V;
				cmd.fetch = 1'b1;
				cmd.wb    = 1'b1;
				cmd.last  = 1'b1;
				cmd.st    = bfpm_pkg::ST_OK;
			end
			bfpm_pkg::S_FLUSH: begin
				cmd.src = bfpm_pkg::SRC_PEND;
				if (stat.sc_fm && stat.sc_pinned) begin
					cmd.sc_inc = 1'b0;
				end else if (stat.sc_fm && stat.sc_dirty) begin
					if (!stat.pend_valid || stat.out_free) begin
						cmd.emit      = stat.pend_valid;
						cmd.pend_load = 1'b1;
						cmd.clr_sc    = 1'b1;
						cmd.sc_inc    = !stat.sc_last;
					end
				end else begin
					cmd.clr_sc = stat.sc_fm;
					cmd.sc_inc = !stat.sc_last;
				end
			end
			bfpm_pkg::S_FL_PIN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.pend_valid) begin
						cmd.src      = bfpm_pkg::SRC_PEND;
						cmd.pend_clr = 1'b1;
					end else begin
						cmd.st   = bfpm_pkg::ST_PINNED;
						cmd.fsel = bfpm_pkg::FS_SC;
						cmd.last = 1'b1;
					end
				end
			end
			bfpm_pkg::S_FL_END: begin
				cmd.last = 1'b1;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.pend_valid) begin
						cmd.src      = bfpm_pkg::SRC_PEND;
						cmd.pend_clr = 1'b1;
					end else begin
						cmd.st = bfpm_pkg::ST_OK;
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule
`default_nettype wire

// File: hdl/buffer_frame_pin_manager.sv
`default_nettype none
// ---------------------------------------------------------------------------
// buffer_frame_pin_manager
// Page frame pool with pin counts, dirty marks and an unpinned frame list.
// ---------------------------------------------------------------------------
// One request is handled at a time. The tag lookup walks the frames one per
// cycle from frame 0 and stops at the first valid match; a pin miss then
// takes a victim from the rear of the unpinned list. Allocate takes the
// victim first, then walks the table and stops at a duplicate. Flush walks
// the frames once, giving one write-back transfer per dirty frame of the
// file, and stops early at a pinned frame of that file, which it reports. The
// result register decouples the two channels; a result waits there until the
// sink takes it, and the walk stalls only when a second result is due.
module buffer_frame_pin_manager #(
	parameter int NUM_FRAMES = 16,
	parameter int PIN_BITS   = 8
) (
	input  wire             clk,
	input  wire             arst_n,
	bfpm_req_if.sink        req,
	bfpm_rsp_if.source      rsp
);
	bfpm_pkg::cmd_t      cmd;
	bfpm_pkg::stat_t     stat;
	bfpm_pkg::in_item_t  in_item;
	bfpm_pkg::out_item_t out_item;
	logic                out_valid;

	// gather request payload
	always_comb begin
		in_item.op          = req.op;
		in_item.file_id     = req.file_id;
		in_item.page_no     = req.page_no;
		in_item.mark_dirty  = req.mark_dirty;
		in_item.keep_recent = req.keep_recent;
	end

	bfpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bfpm_dpath #(
		.NUM_FRAMES (NUM_FRAMES),
		.PIN_BITS   (PIN_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_ready (rsp.ready)
	);

	// drive result channel
	assign rsp.valid    = out_valid;
	assign rsp.status   = out_item.status;
	assign rsp.frame    = out_item.frame;
	assign rsp.hit      = out_item.hit;
	assign rsp.fetch    = out_item.fetch;
	assign rsp.wb_valid = out_item.wb_valid;
	assign rsp.wb_file  = out_item.wb_file;
	assign rsp.wb_page  = out_item.wb_page;
	assign rsp.last     = out_item.last;

`ifndef NO_ASSERTIONS
	// a result is never loaded over one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result register overwritten");

	// a victim is only taken from a non-empty list
	a_victim_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_vic |-> !stat.rear_empty)
		else $error("victim taken from empty list");

	// an accepted request occupies the block
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");
`endif
endmodule
`default_nettype wire
